// ===== rtl/b62_pkg.sv =====
// Shared constants, types and the digit-to-ASCII function of the base-62 encoder.
package b62_pkg;

  // Word and digit widths.
  localparam int ValueW    = 64;
  localparam int ChunkW    = 16;
  localparam int NumChunks = ValueW / ChunkW;
  localparam int ChunkIdxW = $clog2(NumChunks);
  localparam int DigitW    = 6;
  localparam int CharW     = 7;
  localparam int MaxDigits = 11;
  localparam int CntW      = $clog2(MaxDigits + 1);
  localparam int Radix     = 62;

  // One long-division step works on the running remainder followed by one chunk.
  localparam int DivInW = DigitW + ChunkW;

  // Reciprocal of the radix, scaled by 2**RecipShift. It is rounded down, so the
  // estimated quotient is exact or one too small.
  localparam int RecipShift = 28;
  localparam int RecipW     = RecipShift - DigitW + 1;
  localparam int ProdW      = DivInW + RecipW;
  localparam logic [RecipW-1:0] RecipM = RecipW'((64'd1 << RecipShift) / Radix);

  // Alphabet bases.
  localparam logic [CharW-1:0] CharZero   = 7'd48;
  localparam logic [CharW-1:0] CharLowerA = 7'd97;
  localparam logic [CharW-1:0] CharUpperA = 7'd65;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } b62_state_t;

  typedef logic [DigitW-1:0] digit_t;

  // Maps a digit value to its ASCII character: 0-9, then a-z, then A-Z.
  function automatic logic [CharW-1:0] digit_to_char(input digit_t d);
    logic [CharW-1:0] dx;
    dx = CharW'(d);
    if (d < DigitW'(10)) begin
      return CharZero + dx;
    end else if (d < DigitW'(36)) begin
      return CharLowerA + dx - CharW'(10);
    end else begin
      return CharUpperA + dx - CharW'(36);
    end
  endfunction

endpackage

// ===== rtl/b62_if.sv =====
// Valid/ready channel interfaces for the value input and the character output.
interface b62_in_if;
  import b62_pkg::*;

  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface b62_out_if;
  import b62_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] digit_char;
  logic             last;

  modport source(output valid, output digit_char, output last, input ready);
  modport sink(input valid, input digit_char, input last, output ready);
endinterface

// ===== rtl/base62_number_encoder_top.sv =====
// Each digit takes one pass of the shared divide-by-62 step over every 16-bit chunk, most significant first;
// the digits of a value with n digits (1 to 11) are then shown one at a time, most significant first.
// The single divide step is reused for each 16-bit chunk, so a value is not overlapped with the next:
// a new word is taken only when the block is idle.
// Reset (synchronous, active low) returns the sequencer to idle and drops output valid.
// Top level of the base-62 encoder: sequencer, quotient register and digit buffer.
module base62_number_encoder_top (
  input logic       clk,
  input logic       rst_n,
  b62_in_if.sink    in_if,
  b62_out_if.source out_if
);
  import b62_pkg::*;

  b62_state_t state_r, state_nxt;

  logic [ValueW-1:0]    val_r, val_nxt;
  logic [ChunkIdxW-1:0] idx_r, idx_nxt;
  digit_t               rem_r, rem_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  digit_t               digs_r [MaxDigits];

  logic [DivInW-1:0] div_in;
  logic [ChunkW-1:0] div_q;
  digit_t            div_rem;
  logic              digit_done;
  logic              in_take;
  logic              out_take;
  logic [CntW-1:0]   rd_idx;

  assign in_take  = in_if.valid && in_if.ready;
  assign out_take = out_if.valid && out_if.ready;

  // Shared divide step over the current chunk, most significant chunk first.
  assign div_in = {rem_r, val_r[idx_r*ChunkW +: ChunkW]};

  b62_div62 u_div (
    .dividend  (div_in),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // The quotient replaces the chunk in place.
  always_comb begin
    val_nxt = val_r;
    val_nxt[idx_r*ChunkW +: ChunkW] = div_q;
  end

  assign digit_done = (state_r == ST_DIV) && (idx_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (digit_done &&
            ((val_nxt == '0) || (cnt_r == CntW'(MaxDigits - 1)))) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_take && (cnt_r == CntW'(1))) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    idx_nxt = idx_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          idx_nxt = ChunkIdxW'(NumChunks - 1);
          rem_nxt = '0;
          cnt_nxt = '0;
        end
      end
      ST_DIV: begin
        if (digit_done) begin
          idx_nxt = ChunkIdxW'(NumChunks - 1);
          rem_nxt = '0;
          cnt_nxt = cnt_r + CntW'(1);
        end else begin
          idx_nxt = idx_r - ChunkIdxW'(1);
          rem_nxt = div_rem;
        end
      end
      ST_EMIT: begin
        if (out_take) cnt_nxt = cnt_r - CntW'(1);
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Payload registers and the digit buffer, least significant digit at index zero.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    rem_r <= rem_nxt;
    if (state_r == ST_IDLE && in_take) begin
      val_r <= in_if.value;
    end else if (state_r == ST_DIV) begin
      val_r <= val_nxt;
    end
    if (digit_done) begin
      digs_r[cnt_r] <= div_rem;
    end
  end

  // Handshake and output word, most significant digit first.
  assign rd_idx = cnt_r - CntW'(1);

  always_comb begin
    in_if.ready       = (state_r == ST_IDLE);
    out_if.valid      = (state_r == ST_EMIT);
    out_if.digit_char = digit_to_char(digs_r[rd_idx]);
    out_if.last       = (cnt_r == CntW'(1));
  end

endmodule

// ===== rtl/b62_div62.sv =====
// One long-division step by 62: remainder and one chunk in, quotient chunk and remainder out.
module b62_div62 (
  input  logic [b62_pkg::DivInW-1:0] dividend,
  output logic [b62_pkg::ChunkW-1:0] quotient,
  output b62_pkg::digit_t            remainder
);
  import b62_pkg::*;

  logic [ProdW-1:0]  prod;
  logic [ChunkW-1:0] q_est;
  logic [DivInW-1:0] rem_est;

  // Estimate the quotient with the scaled reciprocal.
  assign prod  = ProdW'(dividend) * ProdW'(RecipM);
  assign q_est = prod[RecipShift +: ChunkW];

  // The estimate is exact or one short, so a single correction finishes it.
  assign rem_est = dividend - DivInW'(q_est) * DivInW'(Radix);

  always_comb begin
    if (rem_est >= DivInW'(Radix)) begin
      quotient  = q_est + ChunkW'(1);
      remainder = DigitW'(rem_est - DivInW'(Radix));
    end else begin
      quotient  = q_est;
      remainder = DigitW'(rem_est);
    end
  end

endmodule

// ===== rtl/b62_checker.sv =====
// Port-level checker for the base-62 encoder, bound to the top level.
module b62_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [b62_pkg::CharW-1:0] out_digit_char,
  input logic                      out_last
);
  import b62_pkg::*;

  // A stalled output word holds its character and flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char) && $stable(out_last))
    else $error("output word changed while stalled");

  // Input is never taken while characters are still being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while output pending");

  // An accepted value starts the divide phase, so nothing is shown right after.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("block not busy after accepting a value");

  // After the last character is taken the block is idle again.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("block did not return to idle after last character");

  // Every character lies in the base-62 alphabet range.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= CharZero) && (out_digit_char <= 7'd122))
    else $error("character outside the alphabet");

endmodule

bind base62_number_encoder_top b62_checker u_b62_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_digit_char (out_if.digit_char),
  .out_last       (out_if.last)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the base-62 encoder: random and directed values, checked digit by digit.
module testbench;
  import b62_pkg::*;

  localparam int unsigned DIGIT_RADIX  = 62;
  localparam int          IDLE_PCT     = 8;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_ITEMS = 100;

  // One expected character of the encoded text.
  typedef struct packed {
    logic [CharW-1:0] digit_char;
    logic             last;
  } digit_word_t;

  logic clk = 1'b0;
  logic rst_n;

  b62_in_if  in_ch ();
  b62_out_if out_ch ();

  base62_number_encoder_top uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  logic [ValueW-1:0] pending_values[$];
  digit_word_t       expected_digits[$];
  logic              in_taken = 1'b0;
  int                cycle_count = 0;
  int                mismatch_count = 0;
  logic              steady;

  // No idling on either side inside this window.
  assign steady = (cycle_count >= 1500) && (cycle_count < 3500);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ASCII character for one digit value: 0-9, then a-z, then A-Z.
  function automatic logic [CharW-1:0] base62_char(input int unsigned d);
    if (d < 10) begin
      return CharW'(8'd48 + d);
    end else if (d < 36) begin
      return CharW'(8'd97 + d - 10);
    end else begin
      return CharW'(8'd65 + d - 36);
    end
  endfunction

  // Expands one value into its base-62 text, most significant digit first.
  function automatic void predict_digits(input logic [ValueW-1:0] v);
    logic [ValueW-1:0] rest;
    logic [CharW-1:0]  chars[$];
    digit_word_t       w;
    int                n;
    rest = v;
    do begin
      chars.push_front(base62_char(int'(rest % ValueW'(DIGIT_RADIX))));
      rest = rest / ValueW'(DIGIT_RADIX);
    end while (rest != '0);
    n = chars.size();
    for (int k = 0; k < n; k++) begin
      w.digit_char = chars[k];
      w.last       = (k == n - 1);
      expected_digits.push_back(w);
    end
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Input driver: holds a word until it is taken, then offers the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (!(in_ch.valid && !in_taken)) begin
        if (pending_values.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_ch.valid <= 1'b1;
          in_ch.value <= pending_values.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
          in_ch.value <= {$urandom, $urandom};
        end
      end
    end
  end

  // Monitor: predicts on each accepted value and checks each accepted character.
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_digits(in_ch.value);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_digits.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected word: digit_char=%0d last=%0b",
                     out_ch.digit_char, out_ch.last);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          if (out_ch.digit_char !== expected_digits[0].digit_char ||
              out_ch.last !== expected_digits[0].last) begin
            if (mismatch_count < 10) begin
              $display("mismatch: digit_char exp %0d got %0d, last exp %0b got %0b",
                       expected_digits[0].digit_char, out_ch.digit_char,
                       expected_digits[0].last, out_ch.last);
            end
            mismatch_count <= mismatch_count + 1;
          end
          void'(expected_digits.pop_front());
        end
      end
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [ValueW-1:0] v;
    logic [ValueW-1:0] pw;
    int                mode;
    int                wait_cycles;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;

    // Directed values: zero, digit class edges, powers of the radix and the extremes.
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back(64'd35);
    pending_values.push_back(64'd36);
    pending_values.push_back(64'd61);
    pending_values.push_back(64'd62);
    pending_values.push_back(64'd63);
    pending_values.push_back(64'd3843);
    pending_values.push_back(64'd3844);
    pending_values.push_back(64'd839299365868340223);
    pending_values.push_back(64'd839299365868340224);
    pending_values.push_back(64'hFFFF_FFFF);
    pending_values.push_back(64'h1_0000_0000);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'h5555_5555_5555_5555);
    pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFE);
    pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);

    // Random values over a spread of magnitudes.
    repeat (RANDOM_ITEMS) begin
      mode = $urandom_range(0, 3);
      v = {$urandom, $urandom};
      case (mode)
        0: begin
        end
        1: begin
          v = v >> $urandom_range(0, 63);
        end
        2: begin
          pw = 64'd1;
          repeat ($urandom_range(1, 10)) pw = pw * 64'd62;
          v = pw + 64'($urandom_range(0, 2)) - 64'd1;
        end
        default: begin
          v = 64'($urandom_range(0, 300));
        end
      endcase
      pending_values.push_back(v);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_values.size() > 0 || in_ch.valid || expected_digits.size() > 0) begin
      @(posedge clk);
    end
    wait_cycles = 0;
    while (wait_cycles < DRAIN_CYCLES) begin
      @(posedge clk);
      wait_cycles++;
    end

    if (expected_digits.size() != 0) begin
      mismatch_count = mismatch_count + expected_digits.size();
    end
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
